### src/gff_pkg.sv
// Shared types and defaults for the grid flood fill block.
// Used by gff_nbr and grid_flood_fill; depends on nothing else.
`default_nettype none

package gff_pkg;

   localparam int GFF_ROWS       = 8;
   localparam int GFF_COLS       = 8;
   localparam int GFF_COLOR_BITS = 8;

   typedef enum logic [1:0] {
      FUNC_WRITE = 2'd0,
      FUNC_READ  = 2'd1,
      FUNC_FILL  = 2'd2
   } func_type;

   // Cell addressed relative to the current cell
   typedef enum logic [2:0] {
      DIR_SELF  = 3'd0,
      DIR_DOWN  = 3'd1,
      DIR_UP    = 3'd2,
      DIR_RIGHT = 3'd3,
      DIR_LEFT  = 3'd4
   } dir_type;

   typedef enum logic [3:0] {
      ST_CLEAR    = 4'd0,
      ST_IDLE     = 4'd1,
      ST_WRITE    = 4'd2,
      ST_LOOKUP   = 4'd3,
      ST_READ_CHK = 4'd4,
      ST_SEED_CHK = 4'd5,
      ST_POP      = 4'd6,
      ST_POP_WAIT = 4'd7,
      ST_NB       = 4'd8,
      ST_NB_CHK   = 4'd9,
      ST_DONE     = 4'd10
   } state_type;

endpackage

`default_nettype wire

### src/gff_nbr.sv
// Neighbour address unit: steps from the current cell in one direction,
// flags edges of the grid and forms the linear cell address. Uses gff_pkg.
`default_nettype none

module gff_nbr #(
   parameter int ROWS = gff_pkg::GFF_ROWS,
   parameter int COLS = gff_pkg::GFF_COLS
) (
   input  wire logic [$clog2(ROWS)-1:0]      cur_row,
   input  wire logic [$clog2(COLS)-1:0]      cur_col,
   input  wire gff_pkg::dir_type             dir,
   output logic                              nb_ok,
   output logic [$clog2(ROWS)-1:0]           nb_row,
   output logic [$clog2(COLS)-1:0]           nb_col,
   output logic [$clog2(ROWS*COLS)-1:0]      nb_addr
);
   import gff_pkg::*;

   localparam int RB    = $clog2(ROWS);
   localparam int CB    = $clog2(COLS);
   localparam int AW    = $clog2(ROWS * COLS);
   localparam logic [RB-1:0] ROW_LAST = RB'(ROWS - 1);
   localparam logic [CB-1:0] COL_LAST = CB'(COLS - 1);

   always_comb begin
      nb_ok  = 1'b1;
      nb_row = cur_row;
      nb_col = cur_col;
      case (dir)
         DIR_SELF: begin
            nb_ok = 1'b1;
         end
         DIR_DOWN: begin
            nb_ok  = (cur_row != ROW_LAST);
            nb_row = cur_row + 1'b1;
         end
         DIR_UP: begin
            nb_ok  = (cur_row != '0);
            nb_row = cur_row - 1'b1;
         end
         DIR_RIGHT: begin
            nb_ok  = (cur_col != COL_LAST);
            nb_col = cur_col + 1'b1;
         end
         DIR_LEFT: begin
            nb_ok  = (cur_col != '0);
            nb_col = cur_col - 1'b1;
         end
         default: begin
            nb_ok = 1'b0;
         end
      endcase
   end

   assign nb_addr = AW'(nb_row) * AW'(COLS) + AW'(nb_col);

endmodule

`default_nettype wire

### src/grid_flood_fill.sv
// Top level of the grid flood fill block: colour store, fill stack and sequencer.
// Depends on gff_pkg and gff_nbr.
//
// A ROWS x COLS grid of colours takes one operation per request beat: write a
// cell, read a cell, or 4-connected flood fill from a seed cell; each request
// gives one response beat. After reset the block sweeps the grid to zero, one
// cell per cycle, before it takes a request. Each cycle of work makes at most
// one write and one registered read of the colour store, which sets the pace.
// A request outside the grid or with the spare code goes straight to the
// response, and a fill whose seed already holds the fill colour recolours no
// cell. The block is ready for the next request in the same cycle that the
// response is raised. One request is in work at a time; a finished response
// waits in its output register while the block returns to idle.
`default_nettype none

module grid_flood_fill #(
   parameter int ROWS       = gff_pkg::GFF_ROWS,
   parameter int COLS       = gff_pkg::GFF_COLS,
   parameter int COLOR_BITS = gff_pkg::GFF_COLOR_BITS
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [15:0] req_tdata,   // func[1:0], row[4:2], col[7:5], color[15:8]
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [15:0]      rsp_tdata    // cell_value[7:0], filled_count[14:8], zero[15]
);
   import gff_pkg::*;

   localparam int CELLS = ROWS * COLS;
   localparam int RB    = $clog2(ROWS);
   localparam int CB    = $clog2(COLS);
   localparam int AW    = $clog2(CELLS);
   localparam int TW    = $clog2(CELLS + 1);
   localparam int SW    = RB + CB;
   localparam logic [AW-1:0] ADDR_LAST = AW'(CELLS - 1);

   // Request fields
   func_type             req_func;
   logic [2:0]           req_row;
   logic [2:0]           req_col;
   logic [7:0]           req_color;
   logic                 req_inside;

   assign req_func   = func_type'(req_tdata[1:0]);
   assign req_row    = req_tdata[4:2];
   assign req_col    = req_tdata[7:5];
   assign req_color  = req_tdata[15:8];
   assign req_inside = (32'(req_row) < ROWS) && (32'(req_col) < COLS);

   // Registers
   state_type            state_ff, state_in;
   logic [AW-1:0]        clr_ptr_ff, clr_ptr_in;
   func_type             func_ff, func_in;
   logic [COLOR_BITS-1:0] color_ff, color_in;
   logic [COLOR_BITS-1:0] old_ff, old_in;
   logic [RB-1:0]        cur_row_ff, cur_row_in;
   logic [CB-1:0]        cur_col_ff, cur_col_in;
   dir_type              dir_ff, dir_in;
   logic [TW-1:0]        top_ff, top_in;
   logic [TW-1:0]        cnt_ff, cnt_in;
   logic [7:0]           value_ff, value_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [7:0]           rsp_value_ff, rsp_value_in;
   logic [6:0]           rsp_count_ff, rsp_count_in;

   // Neighbour unit
   logic                 nb_ok;
   logic [RB-1:0]        nb_row;
   logic [CB-1:0]        nb_col;
   logic [AW-1:0]        nb_addr;

   gff_nbr #(
      .ROWS (ROWS),
      .COLS (COLS)
   ) u_nbr (
      .cur_row (cur_row_ff),
      .cur_col (cur_col_ff),
      .dir     (dir_ff),
      .nb_ok   (nb_ok),
      .nb_row  (nb_row),
      .nb_col  (nb_col),
      .nb_addr (nb_addr)
   );

   // Colour store
   logic [COLOR_BITS-1:0] grid_mem [CELLS];
   logic                  g_we;
   logic [AW-1:0]         g_waddr;
   logic [COLOR_BITS-1:0] g_wdata;
   logic [COLOR_BITS-1:0] g_rdata_ff;

   always_ff @(posedge clock) begin
      if (g_we) begin
         grid_mem[g_waddr] <= g_wdata;
      end
      g_rdata_ff <= grid_mem[nb_addr];
   end

   // Fill stack of pending cells, stored as {row, col}
   logic [SW-1:0]         stk_mem [CELLS];
   logic                  s_we;
   logic [AW-1:0]         s_raddr;
   logic [SW-1:0]         s_rdata_ff;

   always_ff @(posedge clock) begin
      if (s_we) begin
         stk_mem[top_ff[AW-1:0]] <= {nb_row, nb_col};
      end
      s_rdata_ff <= stk_mem[s_raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ptr_ff   <= '0;
         top_ff       <= '0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ptr_ff   <= clr_ptr_in;
         top_ff       <= top_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      func_ff      <= func_in;
      color_ff     <= color_in;
      old_ff       <= old_in;
      cur_row_ff   <= cur_row_in;
      cur_col_ff   <= cur_col_in;
      dir_ff       <= dir_in;
      value_ff     <= value_in;
      rsp_value_ff <= rsp_value_in;
      rsp_count_ff <= rsp_count_in;
   end

   always_comb begin
      state_in     = state_ff;
      clr_ptr_in   = clr_ptr_ff;
      func_in      = func_ff;
      color_in     = color_ff;
      old_in       = old_ff;
      cur_row_in   = cur_row_ff;
      cur_col_in   = cur_col_ff;
      dir_in       = dir_ff;
      top_in       = top_ff;
      cnt_in       = cnt_ff;
      value_in     = value_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_value_in = rsp_value_ff;
      rsp_count_in = rsp_count_ff;
      req_tready   = 1'b0;
      g_we         = 1'b0;
      g_waddr      = nb_addr;
      g_wdata      = color_ff;
      s_we         = 1'b0;
      s_raddr      = AW'(top_ff - 1'b1);

      case (state_ff)
         ST_CLEAR: begin
            g_we       = 1'b1;
            g_waddr    = clr_ptr_ff;
            g_wdata    = '0;
            clr_ptr_in = clr_ptr_ff + 1'b1;
            if (clr_ptr_ff == ADDR_LAST) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               func_in    = req_func;
               color_in   = COLOR_BITS'(req_color);
               cur_row_in = RB'(req_row);
               cur_col_in = CB'(req_col);
               dir_in     = DIR_SELF;
               top_in     = '0;
               cnt_in     = '0;
               value_in   = '0;
               if (!req_inside) begin
                  state_in = ST_DONE;
               end else begin
                  case (req_func)
                     FUNC_WRITE: state_in = ST_WRITE;
                     FUNC_READ:  state_in = ST_LOOKUP;
                     FUNC_FILL:  state_in = ST_LOOKUP;
                     default:    state_in = ST_DONE;
                  endcase
               end
            end
         end
         ST_WRITE: begin
            g_we     = 1'b1;
            state_in = ST_DONE;
         end
         ST_LOOKUP: begin
            // seed address is on the read port; data lands next cycle
            state_in = (func_ff == FUNC_READ) ? ST_READ_CHK : ST_SEED_CHK;
         end
         ST_READ_CHK: begin
            value_in = 8'(g_rdata_ff);
            state_in = ST_DONE;
         end
         ST_SEED_CHK: begin
            old_in = g_rdata_ff;
            if (g_rdata_ff == color_ff) begin
               state_in = ST_DONE;
            end else begin
               g_we     = 1'b1;
               s_we     = 1'b1;
               top_in   = top_ff + 1'b1;
               cnt_in   = cnt_ff + 1'b1;
               state_in = ST_POP;
            end
         end
         ST_POP: begin
            if (top_ff == '0) begin
               state_in = ST_DONE;
            end else begin
               top_in   = top_ff - 1'b1;
               state_in = ST_POP_WAIT;
            end
         end
         ST_POP_WAIT: begin
            cur_row_in = s_rdata_ff[SW-1:CB];
            cur_col_in = s_rdata_ff[CB-1:0];
            dir_in     = DIR_DOWN;
            state_in   = ST_NB;
         end
         ST_NB, ST_NB_CHK: begin
            if (state_ff == ST_NB && nb_ok) begin
               // neighbour read issued; check it next cycle
               state_in = ST_NB_CHK;
            end else begin
               if (state_ff == ST_NB_CHK && g_rdata_ff == old_ff) begin
                  g_we   = 1'b1;
                  s_we   = 1'b1;
                  top_in = top_ff + 1'b1;
                  cnt_in = cnt_ff + 1'b1;
               end
               state_in = ST_NB;
               case (dir_ff)
                  DIR_DOWN:  dir_in = DIR_UP;
                  DIR_UP:    dir_in = DIR_RIGHT;
                  DIR_RIGHT: dir_in = DIR_LEFT;
                  default: begin
                     dir_in   = DIR_SELF;
                     state_in = ST_POP;
                  end
               endcase
            end
         end
         ST_DONE: begin
            // hold until the output register is free
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_value_in = value_ff;
               rsp_count_in = 7'(cnt_ff);
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {1'b0, rsp_count_ff, rsp_value_ff};

`ifndef SYNTHESIS
   a_stack_bound: assert property (@(posedge clock) disable iff (reset)
      top_ff <= TW'(CELLS))
      else $error("fill stack deeper than the grid");

   a_stack_vs_count: assert property (@(posedge clock) disable iff (reset)
      top_ff <= cnt_ff)
      else $error("more cells pending than recoloured");

   a_fill_drained: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE) |-> (top_ff == '0))
      else $error("response formed with cells still pending");

   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_DONE))
      else $error("response beat raised outside completion");
`endif

endmodule

`default_nettype wire
